### design/dca_pkg.sv
`timescale 1ns / 1ps

package dca_pkg;

    // widths fixed by the register map and the word fields
    localparam int unsigned PRESENT_W = 4;
    localparam int unsigned MASK_W    = 16;
    localparam int unsigned ID_W      = 4;
    localparam int unsigned PHY_W     = 2;
    localparam int unsigned MASKS     = 4;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned DATA_W    = 32;

    // result status codes
    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_QUEUED  = 3'd1,
        ST_NOCHG   = 3'd2,
        ST_FREED   = 3'd3,
        ST_HANDED  = 3'd4,
        ST_ERR_PHY = 3'd5
    } t_status;

    // register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_PRESENT = 3'd0,
        REG_RSM     = 3'd1,
        REG_ALLOW0  = 3'd2,
        REG_ALLOW1  = 3'd3,
        REG_ALLOW2  = 3'd4,
        REG_ALLOW3  = 3'd5,
        REG_SPARE6  = 3'd6,
        REG_SPARE7  = 3'd7
    } t_reg;

    // command codes
    localparam logic CMD_ISSUE   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_GRANT,
        S_RSCAN,
        S_FIN,
        S_OUT
    } t_state;

endpackage

### design/dma_channel_allocator_core.sv
`timescale 1ns / 1ps
// sequence: a word that changes nothing goes from S_LOOK straight to S_OUT, an issue scans
// the physical channels in S_GRANT, and a release scans the channels in S_RSCAN, then S_FIN
// throughput: one word at a time; the next word is taken only after the result word is
// accepted and the sequencer is back in S_IDLE, so result stalls hold off the next word
// scan time comes from the single compare unit stepping one physical or virtual channel a cycle
// reset (synchronous, active low): all channels idle, all physical channels free,
// phy_present = 15, request_select_mode = 0, allow masks = 0
module dma_channel_allocator_core
    import dca_pkg::*;
#(
    parameter int unsigned PHYS           = 4,
    parameter int unsigned SLAVE_CHANNELS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,

    // request word
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic              i_channel_is_slave,
    input  logic [ID_W-1:0]   i_channel_id,

    // result word
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [2:0]        o_status,
    output logic [PHY_W-1:0]  o_phy_index,
    output logic              o_next_is_slave,
    output logic [ID_W-1:0]   o_next_channel_id,

    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // entries 0..PHYS-1 are memcpy channels, the rest slave channels
    localparam int unsigned NCHAN = PHYS + SLAVE_CHANNELS;
    localparam int unsigned CW    = $clog2(NCHAN);
    localparam int unsigned PW    = (PHYS > 1) ? $clog2(PHYS) : 1;

    // configuration registers
    logic [PRESENT_W-1:0] r_present;
    logic                 r_rsm;
    logic [MASK_W-1:0]    r_allow [MASKS];

    // channel and physical channel bookkeeping, one register per entry
    logic                 r_held [NCHAN];
    logic                 r_wait [NCHAN];
    logic [PW-1:0]        r_chphy [NCHAN];
    logic                 r_busy [PHYS];

    // sequencer
    t_state               r_state, n_state;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_entry;
    logic                 r_cmd;
    logic                 r_ok;
    logic [PW-1:0]        r_phy, n_phy;

    // result register
    t_status              r_status, n_status;
    logic [PHY_W-1:0]     r_res_phy, n_res_phy;
    logic                 r_nslave, n_nslave;
    logic [ID_W-1:0]      r_nid, n_nid;

    // array update strobes
    logic                 grant_we;
    logic                 queue_we;
    logic                 hand_we;
    logic                 free_we;
    logic                 fin_we;

    // input decode
    logic                 in_ok;
    logic [CW-1:0]        in_entry;

    // shared lookup and permission unit
    logic [CW-1:0]        rd_idx;
    logic                 rd_held;
    logic                 rd_wait;
    logic [PW-1:0]        rd_phy;
    logic [CW-1:0]        perm_e;
    logic [PW-1:0]        perm_p;
    logic [CW-1:0]        perm_sidx;
    logic                 perm_ok;
    logic                 scan_last;

    logic                 cfg_wr;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= PRESENT_W'(15);
            r_rsm     <= 1'b0;
            for (int i = 0; i < MASKS; i++) begin
                r_allow[i] <= '0;
            end
        end else if (cfg_wr) begin
            case (t_reg'(paddr[4:2]))
                REG_PRESENT: r_present  <= pwdata[PRESENT_W-1:0];
                REG_RSM:     r_rsm      <= pwdata[0];
                REG_ALLOW0:  r_allow[0] <= pwdata[MASK_W-1:0];
                REG_ALLOW1:  r_allow[1] <= pwdata[MASK_W-1:0];
                REG_ALLOW2:  r_allow[2] <= pwdata[MASK_W-1:0];
                REG_ALLOW3:  r_allow[3] <= pwdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (t_reg'(paddr[4:2]))
            REG_PRESENT: prdata = DATA_W'(r_present);
            REG_RSM:     prdata = DATA_W'(r_rsm);
            REG_ALLOW0:  prdata = DATA_W'(r_allow[0]);
            REG_ALLOW1:  prdata = DATA_W'(r_allow[1]);
            REG_ALLOW2:  prdata = DATA_W'(r_allow[2]);
            REG_ALLOW3:  prdata = DATA_W'(r_allow[3]);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // input decode: channel ids outside the configured counts are ignored
    // ------------------------------------------------------------------
    always_comb begin
        if (i_channel_is_slave) begin
            in_ok    = ({1'b0, i_channel_id} < 5'(SLAVE_CHANNELS));
            in_entry = CW'(PHYS) + CW'(i_channel_id);
        end else begin
            in_ok    = ({1'b0, i_channel_id} < 5'(PHYS));
            in_entry = CW'(i_channel_id);
        end
    end

    // ------------------------------------------------------------------
    // shared unit: one entry read and one permission check per cycle
    // ------------------------------------------------------------------
    // the release scan walks the virtual channels, everything else looks
    // at the requesting channel
    assign rd_idx  = (r_state == S_RSCAN) ? r_cnt : r_entry;
    assign rd_held = r_held[rd_idx];
    assign rd_wait = r_wait[rd_idx];
    assign rd_phy  = r_chphy[rd_idx];

    // grant scan walks the physical channels for a fixed entry,
    // release scan walks the entries for a fixed physical channel
    assign perm_e    = (r_state == S_RSCAN) ? r_cnt : r_entry;
    assign perm_p    = (r_state == S_RSCAN) ? r_phy : r_cnt[PW-1:0];
    assign perm_sidx = perm_e - CW'(PHYS);
    // memcpy channels may use any physical channel
    assign perm_ok   = (perm_e < CW'(PHYS)) || r_rsm
                       || r_allow[2'(perm_p)][4'(perm_sidx)];

    assign scan_last = (r_state == S_RSCAN) ? (r_cnt == CW'(NCHAN - 1))
                                            : (r_cnt == CW'(PHYS - 1));

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_phy     = r_phy;
        n_status  = r_status;
        n_res_phy = r_res_phy;
        n_nslave  = r_nslave;
        n_nid     = r_nid;
        grant_we  = 1'b0;
        queue_we  = 1'b0;
        hand_we   = 1'b0;
        free_we   = 1'b0;
        fin_we    = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                n_status  = ST_NOCHG;
                n_res_phy = '0;
                n_nslave  = 1'b0;
                n_nid     = '0;
                n_cnt     = '0;
                n_state   = S_OUT;
                if (r_ok) begin
                    if (r_cmd == CMD_ISSUE) begin
                        // issue while holding or waiting changes nothing
                        if (!rd_held && !rd_wait) begin
                            n_state = S_GRANT;
                        end
                    end else if (!rd_held) begin
                        n_status = ST_ERR_PHY;
                    end else begin
                        n_phy   = rd_phy;
                        n_state = S_RSCAN;
                    end
                end
            end

            S_GRANT: begin
                // lowest present, permitted, free physical channel wins
                if (r_present[2'(r_cnt[PW-1:0])] && perm_ok && !r_busy[r_cnt[PW-1:0]]) begin
                    grant_we  = 1'b1;
                    n_status  = ST_GRANTED;
                    n_res_phy = PHY_W'(r_cnt[PW-1:0]);
                    n_state   = S_OUT;
                end else if (scan_last) begin
                    queue_we = 1'b1;
                    n_status = ST_QUEUED;
                    n_state  = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_RSCAN: begin
                // memcpy entries come first, so the first hit is the right heir
                n_res_phy = PHY_W'(r_phy);
                if (rd_wait && perm_ok) begin
                    hand_we  = 1'b1;
                    n_status = ST_HANDED;
                    if (r_cnt >= CW'(PHYS)) begin
                        n_nslave = 1'b1;
                        n_nid    = ID_W'(r_cnt - CW'(PHYS));
                    end else begin
                        n_nslave = 1'b0;
                        n_nid    = ID_W'(r_cnt);
                    end
                    n_state = S_FIN;
                end else if (scan_last) begin
                    free_we  = 1'b1;
                    n_status = ST_FREED;
                    n_state  = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_FIN: begin
                // releasing channel goes back to idle
                fin_we  = 1'b1;
                n_state = S_OUT;
            end

            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // word capture and scan registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd   <= i_cmd;
            r_ok    <= in_ok;
            r_entry <= in_ok ? in_entry : '0;
        end
        r_phy     <= n_phy;
        r_status  <= n_status;
        r_res_phy <= n_res_phy;
        r_nslave  <= n_nslave;
        r_nid     <= n_nid;
    end

    // channel and physical channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCHAN; i++) begin
                r_held[i]  <= 1'b0;
                r_wait[i]  <= 1'b0;
                r_chphy[i] <= '0;
            end
            for (int i = 0; i < PHYS; i++) begin
                r_busy[i] <= 1'b0;
            end
        end else begin
            if (grant_we) begin
                r_busy[r_cnt[PW-1:0]] <= 1'b1;
                r_held[r_entry]       <= 1'b1;
                r_chphy[r_entry]      <= r_cnt[PW-1:0];
            end
            if (queue_we) begin
                r_wait[r_entry] <= 1'b1;
            end
            if (hand_we) begin
                // physical channel stays busy under its new owner
                r_held[r_cnt]  <= 1'b1;
                r_wait[r_cnt]  <= 1'b0;
                r_chphy[r_cnt] <= r_phy;
            end
            if (free_we) begin
                r_busy[r_phy] <= 1'b0;
            end
            if (fin_we) begin
                r_held[r_entry] <= 1'b0;
                r_wait[r_entry] <= 1'b0;
            end
        end
    end

    // result word
    assign o_status          = r_status;
    assign o_phy_index       = r_res_phy;
    assign o_next_is_slave   = r_nslave;
    assign o_next_channel_id = r_nid;

endmodule

### test/tb_dma_channel_allocator_core.sv
`timescale 1ns / 1ps

module tb_dma_channel_allocator_core;
    import dca_pkg::*;

    // block size used throughout, matches the instance below
    localparam int unsigned N_PHY       = 4;
    localparam int unsigned N_SLAVE     = 16;
    localparam int unsigned N_ENT       = N_PHY + N_SLAVE;
    localparam logic [5:0]  OWNER_NONE  = 6'd63;
    localparam logic [2:0]  PHY_NONE    = 3'd4;
    localparam int unsigned RAND_PHASES = 16;
    localparam int unsigned PHASE_WORDS = 112;
    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int unsigned DRAIN_WAIT  = 30;

    // per virtual channel bookkeeping
    typedef enum logic [1:0] {
        CH_IDLE,
        CH_WAITING,
        CH_RUNNING
    } t_ch_mode;

    // one result word as the block should produce it
    typedef struct packed {
        t_status            status;
        logic [PHY_W-1:0]   phy;
        logic               nslave;
        logic [ID_W-1:0]    nid;
    } t_alloc_outcome;

    // tracks who owns which physical channel and predicts every result word;
    // entries below N_PHY are memcpy channels, the rest slave channels
    class phy_ownership_board;
        logic [PRESENT_W-1:0] present;
        logic                 any_slave_ok;
        logic [MASK_W-1:0]    allow [MASKS];
        logic [5:0]           owner [N_PHY];
        t_ch_mode             mode [N_ENT];
        logic [2:0]           held [N_ENT];
        t_alloc_outcome       awaited [$];
        int unsigned          fail_count;

        function new();
            present      = '1;
            any_slave_ok = 1'b0;
            fail_count   = 0;
            foreach (allow[i]) allow[i] = '0;
            foreach (owner[i]) owner[i] = OWNER_NONE;
            foreach (mode[i]) begin
                mode[i] = CH_IDLE;
                held[i] = PHY_NONE;
            end
        endfunction

        function void write_reg(t_reg idx, logic [DATA_W-1:0] data);
            case (idx)
                REG_PRESENT: present = data[PRESENT_W-1:0];
                REG_RSM:     any_slave_ok = data[0];
                REG_ALLOW0, REG_ALLOW1, REG_ALLOW2, REG_ALLOW3:
                    allow[idx - REG_ALLOW0] = data[MASK_W-1:0];
                default: ;
            endcase
        endfunction

        function bit permitted(int unsigned e, int unsigned p);
            if (e < N_PHY || any_slave_ok)
                return 1'b1;
            return allow[p][e - N_PHY];
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction

        function void note_request(logic cmd, logic slave, logic [ID_W-1:0] id);
            t_alloc_outcome r;
            int unsigned    e;
            int unsigned    p;
            bit             done;
            r = '{ST_NOCHG, '0, 1'b0, '0};
            if (slave ? (id < N_SLAVE) : (id < N_PHY)) begin
                e = slave ? N_PHY + id : id;
                if (cmd == CMD_ISSUE) begin
                    if (held[e] == PHY_NONE && mode[e] != CH_WAITING) begin
                        r.status = ST_QUEUED;
                        done     = 1'b0;
                        for (p = 0; p < N_PHY; p++) begin
                            if (!done && present[p] && permitted(e, p)
                                && owner[p] == OWNER_NONE) begin
                                owner[p] = 6'(e);
                                held[e]  = 3'(p);
                                mode[e]  = CH_RUNNING;
                                r.status = ST_GRANTED;
                                r.phy    = PHY_W'(p);
                                done     = 1'b1;
                            end
                        end
                        if (!done)
                            mode[e] = CH_WAITING;
                    end
                end else if (held[e] == PHY_NONE) begin
                    r.status = ST_ERR_PHY;
                end else begin
                    p        = held[e][1:0];
                    r.phy    = PHY_W'(p);
                    r.status = ST_FREED;
                    done     = 1'b0;
                    for (int unsigned c = 0; c < N_ENT; c++) begin
                        if (!done && mode[c] == CH_WAITING && permitted(c, p)) begin
                            owner[p] = 6'(c);
                            held[c]  = 3'(p);
                            mode[c]  = CH_RUNNING;
                            r.status = ST_HANDED;
                            r.nslave = (c >= N_PHY);
                            r.nid    = ID_W'((c >= N_PHY) ? c - N_PHY : c);
                            done     = 1'b1;
                        end
                    end
                    if (!done)
                        owner[p] = OWNER_NONE;
                    held[e] = PHY_NONE;
                    mode[e] = CH_IDLE;
                end
            end
            awaited.push_back(r);
        endfunction

        function void check_outcome(logic [2:0] st, logic [PHY_W-1:0] phy, logic ns,
                                    logic [ID_W-1:0] nid);
            t_alloc_outcome w;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result word: status %0d phy %0d next %0d/%0d",
                         $time, st, phy, ns, nid);
                fail_count++;
                return;
            end
            w = awaited.pop_front();
            if ({st, phy, ns, nid} !== w) begin
                $display({"%0t: mismatch: expected status %0d phy %0d next %0d/%0d,",
                          " got status %0d phy %0d next %0d/%0d"},
                         $time, w.status, w.phy, w.nslave, w.nid, st, phy, ns, nid);
                fail_count++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_cmd;
    logic              i_channel_is_slave;
    logic [ID_W-1:0]   i_channel_id;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [2:0]        o_status;
    logic [PHY_W-1:0]  o_phy_index;
    logic              o_next_is_slave;
    logic [ID_W-1:0]   o_next_channel_id;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    phy_ownership_board board = new();

    // set for whole phases so that some stretches run with no gaps at all
    bit no_idle = 1'b0;

    dma_channel_allocator_core #(
        .PHYS           (N_PHY),
        .SLAVE_CHANNELS (N_SLAVE)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_cmd             (i_cmd),
        .i_channel_is_slave(i_channel_is_slave),
        .i_channel_id      (i_channel_id),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_phy_index       (o_phy_index),
        .o_next_is_slave   (o_next_is_slave),
        .o_next_channel_id (o_next_channel_id),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // gap length: mostly none or short, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // allow mask with the all-clear and all-set cases well represented
    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return MASK_W'($urandom);
        endcase
    endfunction

    // one request word; valid stays high afterwards so a back-to-back word
    // needs no second assignment in the same step
    task automatic send_word(input logic cmd, input logic slave, input logic [ID_W-1:0] id);
        int unsigned gap;
        gap = no_idle ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_cmd              <= cmd;
        i_channel_is_slave <= slave;
        i_channel_id       <= id;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_request(cmd, slave, id);
    endtask

    // register write: setup then access; the bus is left selected so that
    // a following write can start in the very next cycle
    task automatic reg_write(input t_reg idx, input logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, data);
    endtask

    task automatic bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all six registers, junk in the unused upper bits
    task automatic set_regs(input logic [PRESENT_W-1:0] present, input logic rsm,
                            input logic [MASK_W-1:0] m0, input logic [MASK_W-1:0] m1,
                            input logic [MASK_W-1:0] m2, input logic [MASK_W-1:0] m3);
        reg_write(REG_PRESENT, {$urandom} & ~32'hF | present);
        reg_write(REG_RSM, {$urandom} & ~32'h1 | rsm);
        reg_write(REG_ALLOW0, {$urandom} & ~32'hFFFF | m0);
        reg_write(REG_ALLOW1, {$urandom} & ~32'hFFFF | m1);
        reg_write(REG_ALLOW2, {$urandom} & ~32'hFFFF | m2);
        reg_write(REG_ALLOW3, {$urandom} & ~32'hFFFF | m3);
        bus_idle();
    endtask

    // every word gives one result, so an empty queue means the block is idle
    task automatic wait_drained(input int unsigned extra);
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // next random word: mostly releases of running channels and issues from
    // idle ones, with some noise and some misplaced commands mixed in
    task automatic pick_word(output logic cmd, output logic slave, output logic [ID_W-1:0] id);
        int unsigned r;
        int unsigned e;
        int unsigned start;
        bit          found;
        r     = $urandom_range(0, 99);
        found = 1'b0;
        e     = $urandom_range(0, N_ENT - 1);
        if (r < 8) begin
            cmd   = 1'($urandom);
            slave = 1'($urandom);
            id    = ID_W'($urandom);
        end else begin
            if (r < 50) begin
                start = e;
                for (int unsigned k = 0; k < N_ENT; k++) begin
                    if (!found && board.mode[(start + k) % N_ENT] == CH_RUNNING) begin
                        e     = (start + k) % N_ENT;
                        found = 1'b1;
                    end
                end
            end
            if (found)
                cmd = CMD_RELEASE;
            else if (board.mode[e] == CH_IDLE)
                cmd = ($urandom_range(0, 9) == 0) ? CMD_RELEASE : CMD_ISSUE;
            else
                cmd = 1'($urandom);
            slave = (e >= N_PHY);
            id    = ID_W'((e >= N_PHY) ? e - N_PHY : e);
        end
    endtask

    // result side: random back-pressure, checks every word taken
    initial begin
        int unsigned stall;
        stall = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready)
                board.check_outcome(o_status, o_phy_index, o_next_is_slave, o_next_channel_id);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 3) == 0)
                    stall = idle_len();
            end
        end
    end

    // watchdog: a hung handshake ends the run here
    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // stimulus and verdict
    initial begin
        logic            c;
        logic            s;
        logic [ID_W-1:0] id;
        logic [PRESENT_W-1:0] pres;

        i_rst_n            <= 1'b0;
        i_in_valid         <= 1'b0;
        i_cmd              <= CMD_ISSUE;
        i_channel_is_slave <= 1'b0;
        i_channel_id       <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, reset settings: slaves have no permission anywhere
        for (int unsigned m = 0; m < N_PHY; m++)
            send_word(CMD_ISSUE, 1'b0, ID_W'(m));          // fill every physical channel
        send_word(CMD_ISSUE, 1'b0, 4'd0);                  // issue while holding
        send_word(CMD_ISSUE, 1'b1, 4'd0);                  // queued, lowest slave
        send_word(CMD_ISSUE, 1'b1, 4'd15);                 // queued, highest slave
        send_word(CMD_ISSUE, 1'b1, 4'd15);                 // issue while waiting
        send_word(CMD_RELEASE, 1'b1, 4'd15);               // release while waiting
        send_word(CMD_RELEASE, 1'b1, 4'd3);                // release from idle
        send_word(CMD_ISSUE, 1'b0, 4'd4);                  // memcpy id just out of range
        send_word(CMD_ISSUE, 1'b0, 4'd15);
        send_word(CMD_RELEASE, 1'b0, 4'd15);
        send_word(CMD_RELEASE, 1'b0, 4'd2);                // no permitted waiter: freed

        // let slave 15 onto physical channel 1; spare addresses must be ignored
        wait_drained(4);
        reg_write(REG_ALLOW1, 32'hA5A5_8000);
        reg_write(REG_SPARE6, 32'hFFFF_FFFF);
        reg_write(REG_SPARE7, 32'hFFFF_FFFF);
        bus_idle();
        send_word(CMD_RELEASE, 1'b0, 4'd1);                // handed to slave 15
        send_word(CMD_ISSUE, 1'b0, 4'd2);                  // takes the freed channel
        send_word(CMD_RELEASE, 1'b0, 4'd1);
        send_word(CMD_ISSUE, 1'b0, 4'd1);                  // queued memcpy
        send_word(CMD_RELEASE, 1'b0, 4'd3);                // memcpy waiter goes first

        // request-select mode: slave 0 now fits anywhere
        wait_drained(4);
        reg_write(REG_RSM, 32'hFFFF_FFFF);
        bus_idle();
        send_word(CMD_RELEASE, 1'b1, 4'd15);               // handed to slave 0
        send_word(CMD_RELEASE, 1'b0, 4'd0);

        // nothing present: issues can only queue
        wait_drained(4);
        reg_write(REG_PRESENT, 32'h0);
        bus_idle();
        send_word(CMD_ISSUE, 1'b1, 4'd5);

        // random phases, each with its own register settings
        for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
            wait_drained(4);
            no_idle = (ph % 5 == 3);
            case (ph)
                0:       set_regs('1, 1'b0, '1, '1, '1, '1);
                1:       set_regs('0, 1'($urandom), pick_mask(), pick_mask(),
                                  pick_mask(), pick_mask());
                2:       set_regs('1, 1'b0, '0, '0, '0, '0);
                3:       set_regs('1, 1'b1, '0, '0, '0, '0);
                default: begin
                    pres = ($urandom_range(0, 1) == 0) ? '1 : PRESENT_W'($urandom);
                    set_regs(pres, 1'($urandom), pick_mask(), pick_mask(),
                             pick_mask(), pick_mask());
                end
            endcase
            for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
                pick_word(c, s, id);
                send_word(c, s, id);
            end
        end

        // drain, then allow a few more cycles for any stray result word
        wait_drained(DRAIN_WAIT);
        if (board.fail_count == 0 && board.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
design/dca_pkg.sv
design/dma_channel_allocator_core.sv
test/tb_dma_channel_allocator_core.sv
